// ===== design/i2cram_pkg.sv =====
package i2cram_pkg;

	localparam int unsigned KindW    = 2;
	localparam int unsigned AddrW    = 16;
	localparam int unsigned ByteW    = 8;
	localparam int unsigned BitIdxW  = 4;
	localparam int unsigned InDataW  = 40;
	localparam int unsigned OutDataW = 16;

	localparam logic [ByteW-1:0] DevAddrReset    = 8'h00;
	localparam logic [ByteW-1:0] AckTimeoutReset = 8'd250;
	localparam logic [ByteW-1:0] RwMask          = 8'hFE;
	localparam logic [BitIdxW-1:0] BitsPerByte   = 4'd8;

	// input item kinds
	typedef enum logic [KindW-1:0] {
		KIND_TICK  = 2'd0,
		KIND_WRITE = 2'd1,
		KIND_READ  = 2'd2,
		KIND_DATA  = 2'd3
	} kind_t;

	// configuration register indexes
	typedef enum logic {
		REG_DEV_ADDR    = 1'b0,
		REG_ACK_TIMEOUT = 1'b1
	} reg_idx_t;

	// bus sequencer phases
	typedef enum logic [4:0] {
		PH_IDLE      = 5'd0,
		PH_START1    = 5'd1,
		PH_START2    = 5'd2,
		PH_START3    = 5'd3,
		PH_SEND_SET  = 5'd4,
		PH_SEND_HIGH = 5'd5,
		PH_SEND_LOW  = 5'd6,
		PH_ACK_REL   = 5'd7,
		PH_ACK_HIGH  = 5'd8,
		PH_ACK_POLL  = 5'd9,
		PH_ACK_LOW   = 5'd10,
		PH_WAIT_DATA = 5'd11,
		PH_RS1       = 5'd12,
		PH_RS2       = 5'd13,
		PH_RD_HIGH   = 5'd14,
		PH_RD_LOW    = 5'd15,
		PH_MA_SET    = 5'd16,
		PH_MA_HIGH   = 5'd17,
		PH_MA_LOW    = 5'd18,
		PH_MA_REL    = 5'd19,
		PH_STOP_A    = 5'd20,
		PH_STOP_B    = 5'd21,
		PH_STOP_C    = 5'd22,
		PH_STOP_D    = 5'd23
	} phase_t;

	// which byte of the transaction is on the wire
	typedef enum logic [2:0] {
		ST_DEV_WR  = 3'd0,
		ST_REG_HI  = 3'd1,
		ST_REG_LO  = 3'd2,
		ST_WR_DATA = 3'd3,
		ST_DEV_RD  = 3'd4,
		ST_RD_DATA = 3'd5
	} stage_t;

	// one result item, lowest member last so it packs scl at bit 0
	typedef struct packed {
		logic             error;
		logic             done_res;
		logic             busy_res;
		logic             need_data;
		logic             rd_valid;
		logic [ByteW-1:0] rd_data;
		logic             sda_out;
		logic             scl;
	} res_t;

endpackage

// ===== design/i2cram_seq.sv =====
module i2cram_seq (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             en,
	input  logic [i2cram_pkg::KindW-1:0]     kind,
	input  logic [i2cram_pkg::AddrW-1:0]     reg_addr,
	input  logic [i2cram_pkg::ByteW-1:0]     byte_count,
	input  logic [i2cram_pkg::ByteW-1:0]     wr_data,
	input  logic                             sda_in,
	input  logic [i2cram_pkg::ByteW-1:0]     dev_addr,
	input  logic [i2cram_pkg::ByteW-1:0]     ack_timeout,
	output i2cram_pkg::res_t                 res
);

	i2cram_pkg::phase_t                  phase_q, phase_d;
	i2cram_pkg::stage_t                  stage_q, stage_d;
	logic [i2cram_pkg::BitIdxW-1:0]      bit_index_q, bit_index_d;
	logic [i2cram_pkg::ByteW-1:0]        shift_q, shift_d;
	logic [i2cram_pkg::ByteW-1:0]        bytes_left_q, bytes_left_d;
	logic [i2cram_pkg::ByteW-1:0]        wait_count_q, wait_count_d;
	logic [i2cram_pkg::AddrW-1:0]        held_addr_q, held_addr_d;
	logic                                is_read_q, is_read_d;
	logic                                scl_q, scl_d;
	logic                                sda_q, sda_d;
	logic                                err_q, err_d;
	logic [i2cram_pkg::BitIdxW-1:0]      bit_inc;
	logic [i2cram_pkg::ByteW-1:0]        bytes_dec;
	logic [i2cram_pkg::ByteW-1:0]        shift_in;
	logic                                rdv, done, errout;

	assign bit_inc   = bit_index_q + 1'b1;
	assign bytes_dec = (bytes_left_q != '0) ? bytes_left_q - 1'b1 : bytes_left_q;
	assign shift_in  = {shift_q[i2cram_pkg::ByteW-2:0], sda_in};

	// advance the bus sequencer by one item
	always_comb begin
		phase_d      = phase_q;
		stage_d      = stage_q;
		bit_index_d  = bit_index_q;
		shift_d      = shift_q;
		bytes_left_d = bytes_left_q;
		wait_count_d = wait_count_q;
		held_addr_d  = held_addr_q;
		is_read_d    = is_read_q;
		scl_d        = scl_q;
		sda_d        = sda_q;
		err_d        = err_q;
		rdv          = 1'b0;
		done         = 1'b0;
		errout       = 1'b0;
		unique case (i2cram_pkg::kind_t'(kind))
			i2cram_pkg::KIND_WRITE, i2cram_pkg::KIND_READ: begin
				if (phase_q == i2cram_pkg::PH_IDLE) begin
					held_addr_d  = reg_addr;
					bytes_left_d = (byte_count != '0) ? byte_count : 8'd1;
					is_read_d    = (i2cram_pkg::kind_t'(kind) == i2cram_pkg::KIND_READ);
					err_d        = 1'b0;
					shift_d      = dev_addr & i2cram_pkg::RwMask;
					bit_index_d  = '0;
					stage_d      = i2cram_pkg::ST_DEV_WR;
					scl_d        = 1'b1;
					sda_d        = 1'b1;
					phase_d      = i2cram_pkg::PH_START1;
				end
			end
			i2cram_pkg::KIND_DATA: begin
				if (phase_q == i2cram_pkg::PH_WAIT_DATA) begin
					shift_d     = wr_data;
					bit_index_d = '0;
					stage_d     = i2cram_pkg::ST_WR_DATA;
					phase_d     = i2cram_pkg::PH_SEND_SET;
				end
			end
			default: begin
				unique case (phase_q)
					i2cram_pkg::PH_START1: begin
						sda_d = 1'b0; phase_d = i2cram_pkg::PH_START2;
					end
					i2cram_pkg::PH_START2: begin
						scl_d = 1'b0; phase_d = i2cram_pkg::PH_START3;
					end
					i2cram_pkg::PH_START3: begin
						bit_index_d = '0; phase_d = i2cram_pkg::PH_SEND_SET;
					end
					i2cram_pkg::PH_SEND_SET: begin
						sda_d   = shift_q[i2cram_pkg::ByteW-1];
						shift_d = {shift_q[i2cram_pkg::ByteW-2:0], 1'b0};
						phase_d = i2cram_pkg::PH_SEND_HIGH;
					end
					i2cram_pkg::PH_SEND_HIGH: begin
						scl_d = 1'b1; phase_d = i2cram_pkg::PH_SEND_LOW;
					end
					i2cram_pkg::PH_SEND_LOW: begin
						scl_d       = 1'b0;
						bit_index_d = bit_inc;
						phase_d     = (bit_inc >= i2cram_pkg::BitsPerByte) ?
							i2cram_pkg::PH_ACK_REL : i2cram_pkg::PH_SEND_SET;
					end
					i2cram_pkg::PH_ACK_REL: begin
						sda_d = 1'b1; phase_d = i2cram_pkg::PH_ACK_HIGH;
					end
					i2cram_pkg::PH_ACK_HIGH: begin
						scl_d        = 1'b1;
						wait_count_d = '0;
						phase_d      = i2cram_pkg::PH_ACK_POLL;
					end
					i2cram_pkg::PH_ACK_POLL: begin
						if (!sda_in) begin
							scl_d   = 1'b0;
							phase_d = i2cram_pkg::PH_ACK_LOW;
						end else if (wait_count_q >= ack_timeout) begin
							err_d   = 1'b1;
							phase_d = i2cram_pkg::PH_STOP_A;
						end else begin
							wait_count_d = wait_count_q + 1'b1;
						end
					end
					i2cram_pkg::PH_ACK_LOW: begin
						// pick the next byte once the slave has acked
						unique case (stage_q)
							i2cram_pkg::ST_DEV_WR: begin
								shift_d     = held_addr_q[i2cram_pkg::AddrW-1 -: i2cram_pkg::ByteW];
								bit_index_d = '0;
								stage_d     = i2cram_pkg::ST_REG_HI;
								phase_d     = i2cram_pkg::PH_SEND_SET;
							end
							i2cram_pkg::ST_REG_HI: begin
								shift_d     = held_addr_q[i2cram_pkg::ByteW-1:0];
								bit_index_d = '0;
								stage_d     = i2cram_pkg::ST_REG_LO;
								phase_d     = i2cram_pkg::PH_SEND_SET;
							end
							i2cram_pkg::ST_REG_LO: begin
								if (is_read_q) begin
									shift_d     = (dev_addr & i2cram_pkg::RwMask) | 8'd1;
									bit_index_d = '0;
									stage_d     = i2cram_pkg::ST_DEV_RD;
									phase_d     = i2cram_pkg::PH_RS1;
								end else begin
									phase_d = i2cram_pkg::PH_WAIT_DATA;
								end
							end
							i2cram_pkg::ST_WR_DATA: begin
								bytes_left_d = bytes_dec;
								phase_d      = (bytes_dec == '0) ?
									i2cram_pkg::PH_STOP_A : i2cram_pkg::PH_WAIT_DATA;
							end
							i2cram_pkg::ST_DEV_RD: begin
								shift_d     = '0;
								bit_index_d = '0;
								stage_d     = i2cram_pkg::ST_RD_DATA;
								phase_d     = i2cram_pkg::PH_RD_HIGH;
							end
							default: phase_d = i2cram_pkg::PH_STOP_A;
						endcase
					end
					i2cram_pkg::PH_RS1: begin
						sda_d = 1'b1; phase_d = i2cram_pkg::PH_RS2;
					end
					i2cram_pkg::PH_RS2: begin
						scl_d = 1'b1; phase_d = i2cram_pkg::PH_START1;
					end
					i2cram_pkg::PH_RD_HIGH: begin
						sda_d   = 1'b1;
						scl_d   = 1'b1;
						phase_d = i2cram_pkg::PH_RD_LOW;
					end
					i2cram_pkg::PH_RD_LOW: begin
						shift_d     = shift_in;
						scl_d       = 1'b0;
						bit_index_d = bit_inc;
						if (bit_inc >= i2cram_pkg::BitsPerByte) begin
							rdv          = 1'b1;
							bytes_left_d = bytes_dec;
							phase_d      = i2cram_pkg::PH_MA_SET;
						end else begin
							phase_d = i2cram_pkg::PH_RD_HIGH;
						end
					end
					i2cram_pkg::PH_MA_SET: begin
						// nack the last byte, ack the others
						sda_d   = (bytes_left_q == '0);
						phase_d = i2cram_pkg::PH_MA_HIGH;
					end
					i2cram_pkg::PH_MA_HIGH: begin
						scl_d = 1'b1; phase_d = i2cram_pkg::PH_MA_LOW;
					end
					i2cram_pkg::PH_MA_LOW: begin
						scl_d   = 1'b0;
						phase_d = (bytes_left_q == '0) ?
							i2cram_pkg::PH_STOP_A : i2cram_pkg::PH_MA_REL;
					end
					i2cram_pkg::PH_MA_REL: begin
						sda_d       = 1'b1;
						shift_d     = '0;
						bit_index_d = '0;
						stage_d     = i2cram_pkg::ST_RD_DATA;
						phase_d     = i2cram_pkg::PH_RD_HIGH;
					end
					i2cram_pkg::PH_STOP_A: begin
						scl_d = 1'b0; phase_d = i2cram_pkg::PH_STOP_B;
					end
					i2cram_pkg::PH_STOP_B: begin
						sda_d = 1'b0; phase_d = i2cram_pkg::PH_STOP_C;
					end
					i2cram_pkg::PH_STOP_C: begin
						scl_d = 1'b1; phase_d = i2cram_pkg::PH_STOP_D;
					end
					i2cram_pkg::PH_STOP_D: begin
						sda_d   = 1'b1;
						done    = 1'b1;
						errout  = err_q;
						err_d   = 1'b0;
						phase_d = i2cram_pkg::PH_IDLE;
					end
					default: ;
				endcase
			end
		endcase
	end

	// build the result item from the updated state
	always_comb begin
		res.scl       = scl_d;
		res.sda_out   = sda_d;
		res.rd_data   = rdv ? shift_d : '0;
		res.rd_valid  = rdv;
		res.need_data = (phase_d == i2cram_pkg::PH_WAIT_DATA);
		res.busy_res  = (phase_d != i2cram_pkg::PH_IDLE);
		res.done_res  = done;
		res.error     = errout;
	end

	// hold sequencer state, update on each processed item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= i2cram_pkg::PH_IDLE;
			stage_q      <= i2cram_pkg::ST_DEV_WR;
			bit_index_q  <= '0;
			shift_q      <= '0;
			bytes_left_q <= '0;
			wait_count_q <= '0;
			held_addr_q  <= '0;
			is_read_q    <= 1'b0;
			scl_q        <= 1'b1;
			sda_q        <= 1'b1;
			err_q        <= 1'b0;
		end else if (en) begin
			phase_q      <= phase_d;
			stage_q      <= stage_d;
			bit_index_q  <= bit_index_d;
			shift_q      <= shift_d;
			bytes_left_q <= bytes_left_d;
			wait_count_q <= wait_count_d;
			held_addr_q  <= held_addr_d;
			is_read_q    <= is_read_d;
			scl_q        <= scl_d;
			sda_q        <= sda_d;
			err_q        <= err_d;
		end
	end

	a_bit_index_range: assert property (@(posedge clk) disable iff (!arst_n)
		bit_index_q <= i2cram_pkg::BitsPerByte)
		else $error("bit counter ran past one byte");

	a_poll_bound: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == i2cram_pkg::PH_ACK_POLL |-> wait_count_q <= ack_timeout)
		else $error("ack wait count passed the timeout");

	a_wait_data_stage: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == i2cram_pkg::PH_WAIT_DATA |->
			(stage_q == i2cram_pkg::ST_REG_LO || stage_q == i2cram_pkg::ST_WR_DATA) && !is_read_q)
		else $error("waiting for write data outside a write");

	a_idle_released: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == i2cram_pkg::PH_IDLE |-> scl_q && sda_q)
		else $error("bus not released while idle");

endmodule

// ===== design/i2c_register_access_master_core.sv =====
// Channel   Direction  Handshake                  Payload
// s_axis    in         s_axis_tvalid/tready       tuser: kind; tdata: reg_addr, byte_count,
//                                                 wr_data, sda_in
// m_axis    out        m_axis_tvalid/tready       tdata: scl, sda_out, rd_data, rd_valid,
//                                                 need_data, busy_res, done_res, error
// cfg       in         cfg_valid/cfg_ready        cfg_index, cfg_data
//
// Every accepted item yields exactly one result item. Throughput is one item per cycle
// while the result side does not stall: the item passes an input register and the sequencer
// step between it and the result register.
// Reset puts the bus released high with the sequencer idle; configuration is always ready.
// A stalled result holds while one more item waits in the input register.
module i2c_register_access_master_core (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	// [15:0] reg_addr, [23:16] byte_count, [31:24] wr_data, [32] sda_in
	input  logic [i2cram_pkg::InDataW-1:0]      s_axis_tdata,
	// [1:0] kind
	input  logic [i2cram_pkg::KindW-1:0]        s_axis_tuser,
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	// [0] scl, [1] sda_out, [9:2] rd_data, [10] rd_valid, [11] need_data,
	// [12] busy_res, [13] done_res, [14] error
	output logic [i2cram_pkg::OutDataW-1:0]     m_axis_tdata,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic                                cfg_index,
	input  logic [i2cram_pkg::ByteW-1:0]        cfg_data
);

	logic                               in_valid_s1;
	logic [i2cram_pkg::KindW-1:0]       kind_s1;
	logic [i2cram_pkg::AddrW-1:0]       reg_addr_s1;
	logic [i2cram_pkg::ByteW-1:0]       byte_count_s1;
	logic [i2cram_pkg::ByteW-1:0]       wr_data_s1;
	logic                               sda_in_s1;
	logic                               out_valid_s2;
	i2cram_pkg::res_t                   res_s2;
	i2cram_pkg::res_t                   res;
	logic [i2cram_pkg::ByteW-1:0]       dev_addr_q;
	logic [i2cram_pkg::ByteW-1:0]       ack_timeout_q;
	logic                               advance;

	assign advance       = in_valid_s1 && (!out_valid_s2 || m_axis_tready);
	assign s_axis_tready = !in_valid_s1 || advance;
	assign cfg_ready     = 1'b1;

	// capture configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dev_addr_q    <= i2cram_pkg::DevAddrReset;
			ack_timeout_q <= i2cram_pkg::AckTimeoutReset;
		end else if (cfg_valid) begin
			unique case (i2cram_pkg::reg_idx_t'(cfg_index))
				i2cram_pkg::REG_DEV_ADDR:    dev_addr_q    <= cfg_data;
				i2cram_pkg::REG_ACK_TIMEOUT: ack_timeout_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// input register: valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			in_valid_s1 <= s_axis_tvalid;
		end
	end

	// input register: payload
	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			kind_s1       <= s_axis_tuser;
			reg_addr_s1   <= s_axis_tdata[15:0];
			byte_count_s1 <= s_axis_tdata[23:16];
			wr_data_s1    <= s_axis_tdata[31:24];
			sda_in_s1     <= s_axis_tdata[32];
		end
	end

	i2cram_seq u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (advance),
		.kind        (kind_s1),
		.reg_addr    (reg_addr_s1),
		.byte_count  (byte_count_s1),
		.wr_data     (wr_data_s1),
		.sda_in      (sda_in_s1),
		.dev_addr    (dev_addr_q),
		.ack_timeout (ack_timeout_q),
		.res         (res)
	);

	// result register: valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_s2 <= 1'b0;
		end else if (advance) begin
			out_valid_s2 <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_s2 <= 1'b0;
		end
	end

	// result register: payload
	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res;
		end
	end

	assign m_axis_tvalid = out_valid_s2;
	assign m_axis_tdata  = {1'b0, res_s2};

	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_s2 && res_s2.done_res |-> !res_s2.busy_res)
		else $error("done reported while still busy");

	a_error_with_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_s2 && res_s2.error |-> res_s2.done_res)
		else $error("error reported without done");

	a_rd_in_transfer: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_s2 && res_s2.rd_valid |-> res_s2.busy_res && !res_s2.need_data)
		else $error("read byte outside a read transfer");

endmodule

// ===== tb/tb.sv =====
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import i2cram_pkg::*;

	// Bus sequencer mirror plus the queue of line levels still owed by the core
	class bus_trace_board;
		logic [ByteW-1:0]   dev_byte;
		logic [ByteW-1:0]   ack_limit;
		phase_t             ph;
		stage_t             byte_sel;
		logic [BitIdxW-1:0] bit_cnt;
		logic [ByteW-1:0]   shreg;
		logic [ByteW-1:0]   left;
		logic [ByteW-1:0]   poll_cnt;
		logic [AddrW-1:0]   reg_q;
		logic               rd_mode;
		logic               scl_q;
		logic               sda_q;
		logic               fail;
		res_t               levels_due[$];
		int                 mismatches;

		function new();
			dev_byte   = DevAddrReset;
			ack_limit  = AckTimeoutReset;
			ph         = PH_IDLE;
			byte_sel   = ST_DEV_WR;
			bit_cnt    = '0;
			shreg      = '0;
			left       = '0;
			poll_cnt   = '0;
			reg_q      = '0;
			rd_mode    = 1'b0;
			scl_q      = 1'b1;
			sda_q      = 1'b1;
			fail       = 1'b0;
			mismatches = 0;
		endfunction

		function void set_reg(reg_idx_t idx, logic [ByteW-1:0] value);
			case (idx)
			REG_DEV_ADDR: dev_byte = value;
			default: ack_limit = value;
			endcase
		endfunction

		function void load_shift(logic [ByteW-1:0] value, stage_t next_sel);
			shreg    = value;
			bit_cnt  = '0;
			byte_sel = next_sel;
		endfunction

		// Advance the mirror by one accepted item and queue the levels it yields
		function void accept_item(kind_t k, logic [AddrW-1:0] raddr, logic [ByteW-1:0] cnt,
				logic [ByteW-1:0] wd, logic sin);
			res_t r;
			r = '0;
			case (k)
			KIND_WRITE, KIND_READ: begin
				if (ph == PH_IDLE) begin
					reg_q   = raddr;
					left    = (cnt == 0) ? 8'd1 : cnt;
					rd_mode = (k == KIND_READ);
					fail    = 1'b0;
					load_shift(dev_byte & RwMask, ST_DEV_WR);
					scl_q = 1'b1;
					sda_q = 1'b1;
					ph    = PH_START1;
				end
			end
			KIND_DATA: begin
				if (ph == PH_WAIT_DATA) begin
					load_shift(wd, ST_WR_DATA);
					ph = PH_SEND_SET;
				end
			end
			default: begin
				case (ph)
				PH_START1: begin sda_q = 1'b0; ph = PH_START2; end
				PH_START2: begin scl_q = 1'b0; ph = PH_START3; end
				PH_START3: begin bit_cnt = '0; ph = PH_SEND_SET; end
				PH_SEND_SET: begin
					sda_q = shreg[7];
					shreg = {shreg[6:0], 1'b0};
					ph    = PH_SEND_HIGH;
				end
				PH_SEND_HIGH: begin scl_q = 1'b1; ph = PH_SEND_LOW; end
				PH_SEND_LOW: begin
					scl_q   = 1'b0;
					bit_cnt = bit_cnt + 1'b1;
					ph      = (bit_cnt >= BitsPerByte) ? PH_ACK_REL : PH_SEND_SET;
				end
				PH_ACK_REL: begin sda_q = 1'b1; ph = PH_ACK_HIGH; end
				PH_ACK_HIGH: begin
					scl_q    = 1'b1;
					poll_cnt = '0;
					ph       = PH_ACK_POLL;
				end
				PH_ACK_POLL: begin
					if (!sin) begin
						scl_q = 1'b0;
						ph    = PH_ACK_LOW;
					end else if (poll_cnt >= ack_limit) begin
						fail = 1'b1;
						ph   = PH_STOP_A;
					end else begin
						poll_cnt = poll_cnt + 1'b1;
					end
				end
				// pick the next byte once the slave has acked
				PH_ACK_LOW: begin
					case (byte_sel)
					ST_DEV_WR: begin
						load_shift(reg_q[15:8], ST_REG_HI);
						ph = PH_SEND_SET;
					end
					ST_REG_HI: begin
						load_shift(reg_q[7:0], ST_REG_LO);
						ph = PH_SEND_SET;
					end
					ST_REG_LO: begin
						if (rd_mode) begin
							load_shift((dev_byte & RwMask) | 8'h01, ST_DEV_RD);
							ph = PH_RS1;
						end else begin
							ph = PH_WAIT_DATA;
						end
					end
					ST_WR_DATA: begin
						if (left > 0)
							left = left - 1'b1;
						ph = (left == 0) ? PH_STOP_A : PH_WAIT_DATA;
					end
					ST_DEV_RD: begin
						load_shift('0, ST_RD_DATA);
						ph = PH_RD_HIGH;
					end
					default: ph = PH_STOP_A;
					endcase
				end
				PH_RS1: begin sda_q = 1'b1; ph = PH_RS2; end
				PH_RS2: begin scl_q = 1'b1; ph = PH_START1; end
				PH_RD_HIGH: begin
					sda_q = 1'b1;
					scl_q = 1'b1;
					ph    = PH_RD_LOW;
				end
				PH_RD_LOW: begin
					shreg   = {shreg[6:0], sin};
					scl_q   = 1'b0;
					bit_cnt = bit_cnt + 1'b1;
					if (bit_cnt >= BitsPerByte) begin
						r.rd_valid = 1'b1;
						r.rd_data  = shreg;
						if (left > 0)
							left = left - 1'b1;
						ph = PH_MA_SET;
					end else begin
						ph = PH_RD_HIGH;
					end
				end
				PH_MA_SET: begin
					sda_q = (left == 0);
					ph    = PH_MA_HIGH;
				end
				PH_MA_HIGH: begin scl_q = 1'b1; ph = PH_MA_LOW; end
				PH_MA_LOW: begin
					scl_q = 1'b0;
					ph    = (left == 0) ? PH_STOP_A : PH_MA_REL;
				end
				PH_MA_REL: begin
					sda_q = 1'b1;
					load_shift('0, ST_RD_DATA);
					ph = PH_RD_HIGH;
				end
				PH_STOP_A: begin scl_q = 1'b0; ph = PH_STOP_B; end
				PH_STOP_B: begin sda_q = 1'b0; ph = PH_STOP_C; end
				PH_STOP_C: begin scl_q = 1'b1; ph = PH_STOP_D; end
				PH_STOP_D: begin
					sda_q      = 1'b1;
					r.done_res = 1'b1;
					r.error    = fail;
					fail       = 1'b0;
					ph         = PH_IDLE;
				end
				default: ;
				endcase
			end
			endcase
			r.scl       = scl_q;
			r.sda_out   = sda_q;
			r.need_data = (ph == PH_WAIT_DATA);
			r.busy_res  = (ph != PH_IDLE);
			levels_due.push_back(r);
		endfunction

		function void check_field(string name, logic [7:0] want, logic [7:0] got);
			if (want !== got) begin
				$error("%s: expected %0h, actual %0h", name, want, got);
				mismatches++;
			end
		endfunction

		// Compare one result transaction against the oldest queued levels
		function void compare_levels(logic [OutDataW-1:0] data);
			res_t got;
			res_t want;
			got = data[$bits(res_t)-1:0];
			if (levels_due.size() == 0) begin
				$error("result %h arrived with no item pending", data);
				mismatches++;
				return;
			end
			want = levels_due.pop_front();
			check_field("scl", want.scl, got.scl);
			check_field("sda_out", want.sda_out, got.sda_out);
			check_field("rd_data", want.rd_data, got.rd_data);
			check_field("rd_valid", want.rd_valid, got.rd_valid);
			check_field("need_data", want.need_data, got.need_data);
			check_field("busy_res", want.busy_res, got.busy_res);
			check_field("done_res", want.done_res, got.done_res);
			check_field("error", want.error, got.error);
		endfunction
	endclass

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                s_axis_tvalid = 1'b0;
	logic                s_axis_tready;
	logic [InDataW-1:0]  s_axis_tdata = '0;
	logic [KindW-1:0]    s_axis_tuser = KIND_TICK;
	logic                m_axis_tvalid;
	logic                m_axis_tready = 1'b0;
	logic [OutDataW-1:0] m_axis_tdata;
	logic                cfg_valid = 1'b0;
	logic                cfg_ready;
	logic                cfg_index = REG_DEV_ADDR;
	logic [ByteW-1:0]    cfg_data = '0;

	bus_trace_board board = new();

	// stimulus shaping knobs
	int noise_pct  = 0;
	int late_pct   = 0;
	int nack_pct   = 0;
	int late_left  = 0;
	int counted    = 0;
	bit poll_seen  = 1'b0;
	bit force_nack = 1'b0;
	bit burst_in   = 1'b0;
	bit burst_out  = 1'b0;

	i2c_register_access_master_core dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Check every result transaction
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			board.compare_levels(m_axis_tdata);
	end

	// Stall the result side at random, with stretches of full rate
	initial begin : result_sink
		int stall;
		wait (arst_n === 1'b1);
		forever begin
			if ($urandom_range(0, 39) == 0)
				burst_out = !burst_out;
			stall = burst_out ? 0 : $urandom_range(0, 11);
			if (stall > 0) begin
				m_axis_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!m_axis_tvalid);
		end
	end

	// Drive one input transaction after a random gap; valid stays high on return
	task automatic push_item(kind_t k, logic [AddrW-1:0] ra, logic [ByteW-1:0] bc,
			logic [ByteW-1:0] wd, logic sin);
		int gap;
		if ($urandom_range(0, 49) == 0)
			burst_in = !burst_in;
		gap = burst_in ? 0 : $urandom_range(0, 11);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= k;
		s_axis_tdata  <= {7'b0, sin, wd, bc, ra};
		do @(posedge clk); while (!s_axis_tready);
		board.accept_item(k, ra, bc, wd, sin);
	endtask

	// Choose the next item from the mirrored phase: mostly well-formed traffic
	task automatic drive_one();
		phase_t           ph;
		kind_t            k;
		logic [AddrW-1:0] ra;
		logic [ByteW-1:0] bc;
		logic [ByteW-1:0] wd;
		logic             sin;
		int               pick;
		bit               live;
		ph  = board.ph;
		ra  = 16'($urandom);
		bc  = 8'($urandom);
		wd  = 8'($urandom);
		sin = 1'($urandom);
		if (ph != PH_ACK_POLL)
			poll_seen = 1'b0;
		// keep noise out of the ack poll so a planned missing ack always times out
		if (ph != PH_ACK_POLL && $urandom_range(0, 99) < noise_pct) begin
			// keep noise at idle to ignored kinds so no long transaction sneaks in
			if (ph == PH_IDLE)
				k = ($urandom_range(0, 1) != 0) ? KIND_DATA : KIND_TICK;
			else
				k = kind_t'($urandom_range(0, 3));
		end else begin
			case (ph)
			PH_IDLE: begin
				k = ($urandom_range(0, 1) != 0) ? KIND_READ : KIND_WRITE;
				pick = $urandom_range(0, 99);
				if (pick < 85) begin
					bc = 8'($urandom_range(1, 4));
				end else if (pick < 95) begin
					bc = 8'($urandom_range(5, 16));
				end else begin
					// long counts end early on a missing ack to bound the run
					bc = 8'($urandom_range(0, 255));
					force_nack = (bc > 16);
				end
			end
			PH_WAIT_DATA: k = KIND_DATA;
			PH_ACK_POLL: begin
				k = KIND_TICK;
				if (!poll_seen) begin
					poll_seen = 1'b1;
					if (force_nack || $urandom_range(0, 99) < nack_pct)
						late_left = 1000;
					else if ($urandom_range(0, 99) < late_pct)
						late_left = $urandom_range(1, 3);
					else
						late_left = 0;
					force_nack = 1'b0;
				end
				sin = (late_left > 0);
				if (late_left > 0)
					late_left--;
			end
			default: k = KIND_TICK;
			endcase
		end
		if (k == KIND_WRITE || k == KIND_READ)
			live = (ph == PH_IDLE);
		else if (k == KIND_DATA)
			live = (ph == PH_WAIT_DATA);
		else
			live = (ph != PH_IDLE && ph != PH_WAIT_DATA);
		push_item(k, ra, bc, wd, sin);
		if (live)
			counted++;
	endtask

	task automatic advance_to(phase_t stop);
		while (board.ph != stop && board.ph != PH_IDLE)
			drive_one();
	endtask

	// Drop valid and hold until every queued result has come back
	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		while (board.levels_due.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic program_regs(logic [ByteW-1:0] dev, logic [ByteW-1:0] limit);
		cfg_valid <= 1'b1;
		cfg_index <= REG_DEV_ADDR;
		cfg_data  <= dev;
		do @(posedge clk); while (!cfg_ready);
		board.set_reg(REG_DEV_ADDR, dev);
		cfg_index <= REG_ACK_TIMEOUT;
		cfg_data  <= limit;
		do @(posedge clk); while (!cfg_ready);
		board.set_reg(REG_ACK_TIMEOUT, limit);
		cfg_valid <= 1'b0;
	endtask

	initial begin : stimulus
		int               i;
		logic [ByteW-1:0] dev;
		logic [ByteW-1:0] limit;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part under the reset register values
		push_item(KIND_TICK, 16'h0000, 8'h00, 8'h00, 1'b0);
		push_item(KIND_DATA, 16'h0000, 8'h00, 8'hA5, 1'b1);
		push_item(KIND_WRITE, 16'hFFFF, 8'h00, 8'h00, 1'b1);
		push_item(KIND_READ, 16'h0000, 8'hFF, 8'hFF, 1'b0);
		push_item(KIND_DATA, 16'hFFFF, 8'hFF, 8'h5A, 1'b0);
		advance_to(PH_WAIT_DATA);
		push_item(KIND_TICK, 16'hFFFF, 8'hFF, 8'hFF, 1'b1);
		push_item(KIND_DATA, 16'h0000, 8'h00, 8'hFF, 1'b0);
		advance_to(PH_IDLE);
		push_item(KIND_READ, 16'h0000, 8'h01, 8'h00, 1'b0);
		advance_to(PH_IDLE);
		wait_drained();

		// Zero timeout: the first high sample during the ack poll fails
		program_regs(8'hFF, 8'h00);
		late_pct = 100;
		push_item(KIND_WRITE, 16'h8001, 8'hFF, 8'h00, 1'b0);
		advance_to(PH_IDLE);
		late_pct = 0;
		push_item(KIND_READ, 16'h00FF, 8'h02, 8'h00, 1'b1);
		advance_to(PH_IDLE);
		wait_drained();

		// Random phases, one register setting each
		noise_pct = 6;
		late_pct  = 25;
		nack_pct  = 8;
		for (i = 0; i < 5; i++) begin
			case (i)
			0: begin dev = {7'($urandom), 1'b0}; limit = 8'd3; end
			1: begin dev = 8'hFE; limit = 8'd255; end
			2: begin dev = 8'h00; limit = 8'd1; end
			3: begin dev = 8'($urandom); limit = 8'd0; end
			default: begin dev = {7'($urandom), 1'b0}; limit = 8'($urandom_range(1, 255)); end
			endcase
			program_regs(dev, limit);
			counted = 0;
			while (counted < 380)
				drive_one();
			advance_to(PH_IDLE);
			wait_drained();
		end

		repeat (10) @(posedge clk);
		if (board.mismatches == 0 && board.levels_due.size() == 0) begin
			$display("tb OK");
		end else begin
			$display("tb NOT OK");
		end
		$finish;
	end

	// Abort a hung run
	initial begin
		#2_000_000;
		$display("tb NOT OK");
		$finish;
	end

endmodule

// ===== filelist.f =====
design/i2cram_pkg.sv
design/i2cram_seq.sv
design/i2c_register_access_master_core.sv
tb/tb.sv
